FILE: design/lookq_pkg.sv
// Shared types and constants for the LOOK elevator disk request queue.
// No dependencies; used by lookq_ctrl, lookq_dp and the top level.
package lookq_pkg;

    localparam int QDEPTH = 16;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int PID_W  = 8;
    localparam int TRK_W  = 10;

    typedef enum logic [1:0] {
        OP_REQ = 2'd0,
        OP_CMP = 2'd1,
        OP_CAN = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic serve_new;
        logic set_drop;
        logic set_removed;
        logic promote;
        logic scan_adv;
        logic insert;
        logic purge_step;
        logic purge_end;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic in_service;
        logic full;
        logic svc_match;
        logic scan_hit;
        logic walk_end;
    } t_dp_sts;

endpackage

FILE: design/look_elevator_disk_queue_top.sv
// LOOK elevator disk request queue. A request is taken when start is high and
// busy is low; its result appears for exactly one cycle with o_done high and
// cannot be held off, so the receiver must take it then. A request that goes
// straight to service, is dropped, completes or is ignored passes only the
// decode and done states; a queued request also scans entries for its sweep
// position, and a cancel also purges the queue left after any promotion.
// Both walks read one queue entry per cycle. The sweep direction is written
// through the config channel, which is always ready; the user must write it
// only while idle, as the block itself does not enforce this.
// Depends on lookq_pkg, lookq_ctrl, lookq_dp.
module look_elevator_disk_queue_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          o_done,
    input  logic [1:0]                    i_opcode,
    input  logic [lookq_pkg::PID_W-1:0]   i_pid,
    input  logic [lookq_pkg::TRK_W-1:0]   i_track,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    output logic                          o_busy_res,
    output logic [lookq_pkg::PID_W-1:0]   o_serving_pid,
    output logic [lookq_pkg::TRK_W-1:0]   o_serving_track,
    output logic                          o_removed_valid,
    output logic [lookq_pkg::PID_W-1:0]   o_removed_pid,
    output logic                          o_dropped,
    output logic [lookq_pkg::QCNT_W-1:0]  o_queue_count
);

    lookq_pkg::t_dp_cmd w_cmd;
    lookq_pkg::t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    lookq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    lookq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_opcode        (i_opcode),
        .i_pid           (i_pid),
        .i_track         (i_track),
        .i_cfg_wr        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_busy_res      (o_busy_res),
        .o_serving_pid   (o_serving_pid),
        .o_serving_track (o_serving_track),
        .o_removed_valid (o_removed_valid),
        .o_removed_pid   (o_removed_pid),
        .o_dropped       (o_dropped),
        .o_queue_count   (o_queue_count)
    );

endmodule

FILE: design/lookq_dp.sv
// Datapath: service registers, queue entry array, walk counters and result flags.
// Depends on lookq_pkg.
module lookq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lookq_pkg::t_dp_cmd            i_cmd,
    output lookq_pkg::t_dp_sts            o_sts,
    input  logic [1:0]                    i_opcode,
    input  logic [lookq_pkg::PID_W-1:0]   i_pid,
    input  logic [lookq_pkg::TRK_W-1:0]   i_track,
    input  logic                          i_cfg_wr,
    input  logic                          i_cfg_data,
    output logic                          o_busy_res,
    output logic [lookq_pkg::PID_W-1:0]   o_serving_pid,
    output logic [lookq_pkg::TRK_W-1:0]   o_serving_track,
    output logic                          o_removed_valid,
    output logic [lookq_pkg::PID_W-1:0]   o_removed_pid,
    output logic                          o_dropped,
    output logic [lookq_pkg::QCNT_W-1:0]  o_queue_count
);

    logic                         r_sweep_dir;
    lookq_pkg::t_op               r_op;
    logic [lookq_pkg::PID_W-1:0]  r_pid;
    logic [lookq_pkg::TRK_W-1:0]  r_trk;
    logic                         r_in_service;
    logic [lookq_pkg::PID_W-1:0]  r_svc_pid;
    logic [lookq_pkg::TRK_W-1:0]  r_svc_trk;
    logic [lookq_pkg::QCNT_W-1:0] r_len;
    logic [lookq_pkg::QCNT_W-1:0] r_i;
    logic [lookq_pkg::QCNT_W-1:0] r_k;
    logic                         r_seen;
    logic [lookq_pkg::TRK_W-1:0]  r_ext;
    logic                         r_removed;
    logic [lookq_pkg::PID_W-1:0]  r_removed_pid;
    logic                         r_drop;

    logic [lookq_pkg::PID_W-1:0]  r_qpid [lookq_pkg::QDEPTH];
    logic [lookq_pkg::TRK_W-1:0]  r_qtrk [lookq_pkg::QDEPTH];

    logic [lookq_pkg::QIDX_W-1:0] w_ri;
    logic [lookq_pkg::QIDX_W-1:0] w_wk;
    logic [lookq_pkg::TRK_W-1:0]  w_t;
    logic [lookq_pkg::PID_W-1:0]  w_p;
    logic                         w_down;
    logic                         w_ahead;
    logic                         w_cond;
    logic                         w_ext_upd;

    assign w_ri = r_i[lookq_pkg::QIDX_W-1:0];
    assign w_wk = r_k[lookq_pkg::QIDX_W-1:0];
    assign w_t  = r_qtrk[w_ri];
    assign w_p  = r_qpid[w_ri];
    assign w_down  = r_sweep_dir;
    assign w_ahead = w_down ? (r_svc_trk > r_trk) : (r_svc_trk < r_trk);

    always_comb begin
        if (w_ahead) begin
            if (!w_down) begin
                w_cond    = (r_seen && (w_t <= r_ext)) || (w_t > r_trk);
                w_ext_upd = !r_seen || (w_t > r_ext);
            end else begin
                w_cond    = (r_seen && (w_t >= r_ext)) || (w_t < r_trk);
                w_ext_upd = !r_seen || (w_t < r_ext);
            end
        end else begin
            w_cond    = w_down ? (w_t > r_trk) : (w_t < r_trk);
            w_ext_upd = 1'b0;
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.in_service = r_in_service;
    assign o_sts.full       = (r_len == lookq_pkg::QCNT_W'(lookq_pkg::QDEPTH));
    assign o_sts.svc_match  = r_in_service && (r_svc_pid == r_pid);
    assign o_sts.walk_end   = (r_i == r_len);
    assign o_sts.scan_hit   = (r_i == r_len) || w_cond;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_dir  <= 1'b0;
            r_in_service <= 1'b0;
            r_svc_pid    <= '0;
            r_svc_trk    <= '0;
            r_len        <= '0;
            r_i          <= '0;
            r_k          <= '0;
            r_seen       <= 1'b0;
            r_removed    <= 1'b0;
            r_drop       <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_sweep_dir <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_i       <= '0;
                r_k       <= '0;
                r_seen    <= 1'b0;
                r_removed <= 1'b0;
                r_drop    <= 1'b0;
            end
            if (i_cmd.serve_new) begin
                r_in_service <= 1'b1;
                r_svc_pid    <= r_pid;
                r_svc_trk    <= r_trk;
            end
            if (i_cmd.set_drop) begin
                r_drop <= 1'b1;
            end
            if (i_cmd.set_removed) begin
                r_removed <= 1'b1;
            end
            if (i_cmd.promote) begin
                if (r_len == '0) begin
                    r_in_service <= 1'b0;
                end else begin
                    r_in_service <= 1'b1;
                    r_svc_pid    <= r_qpid[0];
                    r_svc_trk    <= r_qtrk[0];
                    r_len        <= r_len - 1'b1;
                end
            end
            if (i_cmd.scan_adv) begin
                r_i    <= r_i + 1'b1;
                r_seen <= 1'b1;
            end
            if (i_cmd.insert) begin
                r_len <= r_len + 1'b1;
            end
            if (i_cmd.purge_step) begin
                r_i <= r_i + 1'b1;
                if (w_p != r_pid) begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (i_cmd.purge_end) begin
                r_len <= r_k;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= lookq_pkg::t_op'(i_opcode);
            r_pid <= i_pid;
            r_trk <= i_track;
        end
        if (i_cmd.set_removed) begin
            r_removed_pid <= r_svc_pid;
        end
        if (i_cmd.scan_adv && w_ext_upd) begin
            r_ext <= w_t;
        end
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.promote) begin
            for (int j = 0; j < lookq_pkg::QDEPTH - 1; j++) begin
                r_qpid[j] <= r_qpid[j+1];
                r_qtrk[j] <= r_qtrk[j+1];
            end
        end else if (i_cmd.insert) begin
            for (int j = 0; j < lookq_pkg::QDEPTH; j++) begin
                if (lookq_pkg::QCNT_W'(j) == r_i) begin
                    r_qpid[j] <= r_pid;
                    r_qtrk[j] <= r_trk;
                end else if ((j > 0) && (lookq_pkg::QCNT_W'(j) > r_i)) begin
                    r_qpid[j] <= r_qpid[(j > 0) ? j-1 : 0];
                    r_qtrk[j] <= r_qtrk[(j > 0) ? j-1 : 0];
                end
            end
        end else if (i_cmd.purge_step && (w_p != r_pid)) begin
            r_qpid[w_wk] <= w_p;
            r_qtrk[w_wk] <= w_t;
        end
    end

    assign o_busy_res      = r_in_service;
    assign o_serving_pid   = r_in_service ? r_svc_pid : '0;
    assign o_serving_track = r_svc_trk;
    assign o_removed_valid = r_removed;
    assign o_removed_pid   = r_removed ? r_removed_pid : '0;
    assign o_dropped       = r_drop;
    assign o_queue_count   = r_len;

endmodule

FILE: design/lookq_ctrl.sv
// Controller state machine: sequences decode, sorted-insert scan and cancel purge.
// Depends on lookq_pkg.
module lookq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    output logic                  o_done,
    input  lookq_pkg::t_dp_sts    i_sts,
    output lookq_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_PURGE  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    lookq_pkg::OP_REQ: begin
                        if (!i_sts.in_service) begin
                            o_cmd.serve_new = 1'b1;
                            n_state         = S_DONE;
                        end else if (i_sts.full) begin
                            o_cmd.set_drop = 1'b1;
                            n_state        = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    lookq_pkg::OP_CMP: begin
                        o_cmd.set_removed = i_sts.in_service;
                        o_cmd.promote     = 1'b1;
                        n_state           = S_DONE;
                    end
                    lookq_pkg::OP_CAN: begin
                        o_cmd.set_removed = i_sts.svc_match;
                        o_cmd.promote     = i_sts.svc_match;
                        n_state           = S_PURGE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                end
            end
            S_PURGE: begin
                if (i_sts.walk_end) begin
                    o_cmd.purge_end = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.purge_step = 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule
